// ----- rtl/core/stt_pkg.sv -----
// Package for the software timer table: request, result and entry types,
// request and result codes, controller states and default sizes.
// No dependencies.
package stt_pkg;

    localparam int DEFAULT_NUM_ENTRIES = 8;
    localparam int ID_W                = 16;
    localparam int DUR_W               = 16;
    localparam int TIME_W              = 32;

    localparam logic [1:0] REQ_SET    = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ID_W-1:0]  timer_id;
        logic [DUR_W-1:0] duration_ms;
        logic             repeat_req;
    } stt_req_t;

    typedef struct packed {
        logic [1:0]      result_kind;
        logic            ok;
        logic [ID_W-1:0] expired_id;
        logic            last;
    } stt_res_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DUR_W-1:0]  duration;
        logic [TIME_W-1:0] expiry;
        logic              recur;
    } stt_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } stt_state_t;

endpackage

// ----- rtl/core/stt_entry_ram.sv -----
// Entry memory of the timer table: one write port and one read port with
// a registered read that holds its data while no read is issued.
// Depends on stt_pkg.
module stt_entry_ram #(
    parameter int NUM_ENTRIES = stt_pkg::DEFAULT_NUM_ENTRIES,
    parameter int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output stt_pkg::stt_entry_t rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  stt_pkg::stt_entry_t wr_data
);
    import stt_pkg::*;

    stt_entry_t mem [NUM_ENTRIES];
    stt_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/stt_ctrl.sv -----
// Controller of the timer table: request sequencer, entry valid bits,
// millisecond counter, pending result and output register.
// Depends on stt_pkg; drives the ports of stt_entry_ram.
module stt_ctrl #(
    parameter int NUM_ENTRIES = stt_pkg::DEFAULT_NUM_ENTRIES,
    parameter int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stt_pkg::stt_req_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output stt_pkg::stt_res_t   m_data,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_addr,
    input  stt_pkg::stt_entry_t rd_data,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output stt_pkg::stt_entry_t wr_data
);
    import stt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    stt_state_t             state_reg, state_next;
    stt_req_t               req_reg, req_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   res_valid_reg, res_valid_next;
    logic [1:0]             res_kind_reg, res_kind_next;
    logic                   res_ok_reg, res_ok_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic                   out_valid_reg, out_valid_next;
    stt_res_t               out_data_reg, out_data_next;

    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic                   out_free;
    logic                   hit;
    logic                   at_last;

    // Lowest-numbered free entry.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign at_last  = (idx_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            valid_reg     <= '0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            valid_reg     <= valid_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        res_kind_reg <= res_kind_next;
        res_ok_reg   <= res_ok_next;
        res_id_reg   <= res_id_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        now_next       = now_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg;
        res_kind_next  = res_kind_reg;
        res_ok_next    = res_ok_reg;
        res_id_next    = res_id_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        s_ready        = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg + IDX_W'(1);
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data;
        hit            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next = s_data;
                    idx_next = '0;
                    rd_addr  = '0;
                    priority case (s_data.req_type)
                        REQ_SET: begin
                            res_valid_next = 1'b1;
                            res_kind_next  = KIND_SET;
                            res_ok_next    = free_found;
                            res_id_next    = s_data.timer_id;
                            if (free_found) begin
                                wr_en                = 1'b1;
                                wr_addr              = free_idx;
                                wr_data.id           = s_data.timer_id;
                                wr_data.duration     = s_data.duration_ms;
                                wr_data.expiry       = now_reg
                                                     + TIME_W'(s_data.duration_ms);
                                wr_data.recur        = s_data.repeat_req;
                                valid_next[free_idx] = 1'b1;
                            end
                            state_next = ST_FLUSH;
                        end
                        REQ_CANCEL: begin
                            res_valid_next = 1'b1;
                            res_kind_next  = KIND_CANCEL;
                            res_ok_next    = 1'b0;
                            res_id_next    = s_data.timer_id;
                            rd_en          = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        REQ_TICK: begin
                            now_next       = now_reg + TIME_W'(1);
                            res_valid_next = 1'b0;
                            rd_en          = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (req_reg.req_type == REQ_CANCEL) begin
                    hit = valid_reg[idx_reg] && (rd_data.id == req_reg.timer_id);
                    if (hit) begin
                        res_ok_next         = 1'b1;
                        valid_next[idx_reg] = 1'b0;
                        state_next          = ST_FLUSH;
                    end else if (at_last) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                        rd_en    = 1'b1;
                    end
                end else begin
                    hit = valid_reg[idx_reg] && (rd_data.expiry <= now_reg);
                    // An expiry is held back one step so that the final one of the
                    // scan can carry the last flag; a new hit pushes the held one.
                    if (!hit || !res_valid_reg || out_free) begin
                        if (hit) begin
                            if (res_valid_reg) begin
                                out_valid_next           = 1'b1;
                                out_data_next.result_kind = res_kind_reg;
                                out_data_next.ok         = res_ok_reg;
                                out_data_next.expired_id = res_id_reg;
                                out_data_next.last       = 1'b0;
                            end
                            res_valid_next = 1'b1;
                            res_kind_next  = KIND_EXPIRY;
                            res_ok_next    = 1'b1;
                            res_id_next    = rd_data.id;
                            if (rd_data.recur) begin
                                wr_en          = 1'b1;
                                wr_data.expiry = now_reg + TIME_W'(rd_data.duration);
                            end else begin
                                valid_next[idx_reg] = 1'b0;
                            end
                        end
                        if (at_last) begin
                            state_next = ST_FLUSH;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                            rd_en    = 1'b1;
                        end
                    end
                end
            end

            ST_FLUSH: begin
                if (!res_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_data_next.result_kind = res_kind_reg;
                    out_data_next.ok          = res_ok_reg;
                    out_data_next.expired_id  = res_id_reg;
                    out_data_next.last        = 1'b1;
                    res_valid_next            = 1'b0;
                    state_next                = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ----- rtl/core/software_timer_table.sv -----
// Software timer table, top level: entry memory plus controller.
// Depends on stt_pkg, stt_entry_ram and stt_ctrl.
//
// Usage:
// The s_ channel carries requests (set, cancel, one millisecond tick) as an
// stt_req_t; the m_ channel returns results as an stt_res_t, both valid/ready.
// A set or cancel request gives exactly one answer; a tick gives one expiry
// notice per expired entry, in entry order, the final one flagged by last.
// A request with an unused type code is taken and dropped.
// Flow: a set request writes its entry on acceptance, and the flush state
// then loads its answer into the output register. Cancel and tick requests
// scan the memory one entry per cycle through its single read port (a tick
// scan pauses while a held expiry waits); a cancel stops at its first match.
// One request is in work at a time; s_ready is high only while idle.
// Reset clears the counter, every entry's valid bit and the output register;
// memory contents need no clearing, since a free entry is never read as live.
// When the receiver stalls, the finished result waits in the output register
// and a tick scan pauses at the next expired entry until room frees up.
module software_timer_table #(
    parameter int NUM_ENTRIES = stt_pkg::DEFAULT_NUM_ENTRIES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  stt_pkg::stt_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output stt_pkg::stt_res_t m_data
);
    import stt_pkg::*;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    stt_entry_t       rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    stt_entry_t       wr_data;

    stt_entry_ram #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    stt_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

// ----- rtl/core/stt_checker.sv -----
// Port-level checks for the software timer table, bound to the top level.
// Depends on stt_pkg and software_timer_table.
module stt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input stt_pkg::stt_req_t s_data,
    input logic              m_valid,
    input logic              m_ready,
    input stt_pkg::stt_res_t m_data
);
    import stt_pkg::*;

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Set and cancel answers are always the only result of their request.
    a_answer_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind != KIND_EXPIRY) |-> m_data.last)
        else $error("answer without last flag");

    a_expiry_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == KIND_EXPIRY) |-> m_data.ok)
        else $error("expiry notice without ok");

    // A request that does work leaves s_ready low in the cycle after it is taken.
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.req_type != REQ_UNUSED) |=> !s_ready)
        else $error("ready right after a working request");

endmodule

bind software_timer_table stt_checker u_stt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
